### rtl/lped_pkg.sv
`timescale 1ns / 1ps

package lped_pkg;

   // Header layout: 32-bit little-endian total size, then 32-bit little-endian event ID.
   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned HDR_IDX_W    = 3;
   localparam int unsigned WORD_W       = 32;
   localparam int unsigned BYTE_W       = 8;

   // Result kinds, carried on the response tuser.
   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_BAD_SIZE = 2'd2
   } kind_type;

   // One result item as it travels through the output stage.
   typedef struct packed {
      kind_type              kind;
      logic [WORD_W-1:0]     event_id;
      logic [BYTE_W-1:0]     data_byte;
      logic                  last;
   } rsp_type;

endpackage

### rtl/lped_skid.sv
`timescale 1ns / 1ps

module lped_skid
   import lped_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    main_valid_ff;
   logic    main_valid_in;
   rsp_type main_data_ff;
   rsp_type main_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;

   // The skid entry only fills while the main entry is stalled, so upstream
   // may keep sending as long as the skid entry is free.
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // Move the skid entry or a new request into the main entry when it frees up.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
         end else begin
            main_valid_in = in_valid;
            main_data_in  = in_data;
         end
         skid_valid_in = 1'b0;
      end else if (in_valid && in_ready) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid entry is never occupied while the main entry is empty.
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry full while main entry empty");

   // The skid entry fills only when the main entry was held by a stalled receiver.
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!skid_valid_ff && main_valid_ff && !out_ready && in_valid) |=> skid_valid_ff)
      else $error("stalled request not captured in skid entry");

   // While the receiver stalls, the presented result is held.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready) |=> (main_valid_ff && $stable(main_data_ff)))
      else $error("stalled result changed");

endmodule

### rtl/length_prefixed_event_deframer.sv
`timescale 1ns / 1ps

// Length-prefixed event deframer.
// The request channel carries one received byte per transfer. Each message
// starts with an eight-byte header: a 32-bit little-endian total size that
// counts the header itself, then a 32-bit little-endian event ID. Header
// bytes produce no response; each payload byte produces one response tagged
// with the event ID, with tlast on the final byte. A total size of eight
// produces one empty-message response, and a size below eight produces one
// bad-size response, after which the next byte starts a fresh header.
// Throughput is one request per cycle while the skid entry is free; each
// byte only updates the header assembly registers and the payload
// down-counter. Each response reaches rsp_tvalid from the registered output entry.
// When the receiver stalls, the current response is held and one further
// response is caught in a skid entry. req_tready drops while that skid entry
// is occupied, so a stall that catches a response pauses the input until the
// skid entry has moved into the output register.
// Synchronous reset clears the framing state (next byte is the first header
// byte) and empties both output entries.

module length_prefixed_event_deframer
   import lped_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] event_id, [39:32] data_byte
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast    // last_of_message
);

   logic [HDR_IDX_W-1:0] hdr_idx_ff;
   logic [HDR_IDX_W-1:0] hdr_idx_in;
   logic [WORD_W-1:0]    size_ff;
   logic [WORD_W-1:0]    size_in;
   logic [WORD_W-1:0]    id_ff;
   logic [WORD_W-1:0]    id_in;
   logic [WORD_W-1:0]    remain_ff;
   logic [WORD_W-1:0]    remain_in;
   logic                 in_payload_ff;
   logic                 in_payload_in;

   logic                 accept;
   logic                 res_valid;
   rsp_type              res;
   rsp_type              rsp_out;
   logic [WORD_W-1:0]    remain_dec;
   logic [WORD_W-1:0]    size_base;
   logic [WORD_W-1:0]    id_base;
   logic [WORD_W-1:0]    id_full;
   logic [1:0]           lane;

   assign accept     = req_tvalid && req_tready;
   assign remain_dec = remain_ff - WORD_W'(1);
   assign lane       = hdr_idx_ff[1:0];

   // The first header byte clears both assembly words.
   assign size_base  = (hdr_idx_ff == '0) ? '0 : size_ff;
   assign id_base    = (hdr_idx_ff == '0) ? '0 : id_ff;

   // Event ID as it stands once the eighth header byte lands in the top lane.
   assign id_full    = {req_tdata, id_ff[23:0]};

   // Framing step for one accepted byte.
   always_comb begin
      hdr_idx_in    = hdr_idx_ff;
      size_in       = size_ff;
      id_in         = id_ff;
      remain_in     = remain_ff;
      in_payload_in = in_payload_ff;
      res_valid     = 1'b0;
      res.kind      = KIND_PAYLOAD;
      res.event_id  = id_ff;
      res.data_byte = req_tdata;
      res.last      = 1'b0;
      if (accept) begin
         if (in_payload_ff) begin
            // Pass a payload byte through, tagged with the current ID.
            remain_in = remain_dec;
            res_valid = 1'b1;
            if (remain_dec == '0) begin
               in_payload_in = 1'b0;
               res.last      = 1'b1;
            end
         end else begin
            // Place the header byte into its lane of the size or ID word.
            size_in = size_base;
            id_in   = id_base;
            if (!hdr_idx_ff[2]) begin
               size_in[BYTE_W*lane +: BYTE_W] = req_tdata;
            end else begin
               id_in[BYTE_W*lane +: BYTE_W] = req_tdata;
            end
            if (hdr_idx_ff != HDR_IDX_W'(HEADER_BYTES - 1)) begin
               hdr_idx_in = hdr_idx_ff + HDR_IDX_W'(1);
            end else begin
               // Header complete: judge the total size.
               hdr_idx_in    = '0;
               res.event_id  = id_full;
               res.data_byte = '0;
               res.last      = 1'b1;
               if (size_ff < WORD_W'(HEADER_BYTES)) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_BAD_SIZE;
               end else if (size_ff == WORD_W'(HEADER_BYTES)) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_EMPTY;
               end else begin
                  remain_in     = size_ff - WORD_W'(HEADER_BYTES);
                  in_payload_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff    <= '0;
         size_ff       <= '0;
         id_ff         <= '0;
         remain_ff     <= '0;
         in_payload_ff <= 1'b0;
      end else begin
         hdr_idx_ff    <= hdr_idx_in;
         size_ff       <= size_in;
         id_ff         <= id_in;
         remain_ff     <= remain_in;
         in_payload_ff <= in_payload_in;
      end
   end

   // Output register with skid entry.
   lped_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (req_tready),
      .in_data   (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out)
   );

   assign rsp_tdata = {rsp_out.data_byte, rsp_out.event_id};
   assign rsp_tuser = rsp_out.kind;
   assign rsp_tlast = rsp_out.last;

   // While passing payload the header index rests at zero and bytes remain.
   a_payload_state: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (hdr_idx_ff == '0 && remain_ff != '0))
      else $error("payload state inconsistent");

   // Every result other than a payload byte closes its message.
   a_non_payload_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_out.kind != KIND_PAYLOAD) |-> (rsp_tlast && rsp_out.data_byte == '0))
      else $error("empty or bad-size result without tlast");

   // Leaving the payload phase happens only on a request that ends the message.
   a_payload_exit: assert property (@(posedge clock) disable iff (reset)
      (in_payload_ff && accept && remain_ff == WORD_W'(1)) |=> !in_payload_ff)
      else $error("payload phase did not end on its final byte");

endmodule
